FILE: sv/cdc_pkg.sv
package cdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 16;

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [1:0]         action_t;

    localparam action_t ACT_SET = 2'd0;
    localparam action_t ACT_INC = 2'd1;
    localparam action_t ACT_DEC = 2'd2;
    localparam action_t ACT_ADD = 2'd3;

    localparam day_t   DAY_FIRST   = 5'd1;
    localparam day_t   DAY_MAX     = 5'd31;
    localparam day_t   DAY_LEAP_FEB = 5'd29;
    localparam month_t MONTH_JAN   = 4'd1;
    localparam month_t MONTH_FEB   = 4'd2;
    localparam month_t MONTH_DEC   = 4'd12;
    localparam year_t  YEAR_MIN    = 12'd1900;
    localparam year_t  YEAR_MAX    = 12'd2100;
    localparam year_t  YEAR_RESET  = 12'd1900;

    localparam int CENTURY      = 100;
    localparam int QUAD_CENTURY = 400;
    localparam int YEAR_SPAN    = 1 << YEAR_W;
    localparam int N_CENTURY    = (YEAR_SPAN - 1) / CENTURY;
    localparam int N_QUAD       = (YEAR_SPAN - 1) / QUAD_CENTURY;

    localparam day_t MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // multiples of 100 and 400 found by matching against the few that fit in 12 bits
    function automatic logic is_leap(year_t y);
        logic century;
        logic quad;
        century = 1'b0;
        quad    = 1'b0;
        for (int k = 0; k <= N_CENTURY; k++) begin
            if (y == YEAR_W'(k * CENTURY)) begin
                century = 1'b1;
            end
        end
        for (int k = 0; k <= N_QUAD; k++) begin
            if (y == YEAR_W'(k * QUAD_CENTURY)) begin
                quad = 1'b1;
            end
        end
        return quad || (!century && (y[1:0] == 2'b00));
    endfunction

    function automatic day_t days_in(month_t m, year_t y);
        day_t len;
        if (m < MONTH_JAN || m > MONTH_DEC) begin
            len = DAY_MAX;
        end else if (m == MONTH_FEB && is_leap(y)) begin
            len = DAY_LEAP_FEB;
        end else begin
            len = MONTH_LEN[m];
        end
        return len;
    endfunction

endpackage

FILE: sv/calendar_date_counter.sv
// Gregorian date counter holding day, month and year (reset 1 January 1900). Each input
// transfer carries one action: set loads a checked date (bad month -> 1, year outside
// 1900..2100 -> 1900, bad day -> 1), increment and decrement move one day, add moves
// forward add_count days. Every action returns one result with the date before and after;
// the year wraps modulo 4096. Set, increment, decrement and an add of zero finish in the
// accepting cycle; an add of n > 0 days walks the single day-step unit once per cycle,
// up to 65535 days. in_ready is low while an add runs or a result waits with out_ready low.
module calendar_date_counter
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cdc_pkg::action_t action,
    input  cdc_pkg::day_t    set_day,
    input  cdc_pkg::month_t  set_month,
    input  cdc_pkg::year_t   set_year,
    input  cdc_pkg::count_t  add_count,
    output logic             out_valid,
    input  logic             out_ready,
    output cdc_pkg::day_t    new_day,
    output cdc_pkg::month_t  new_month,
    output cdc_pkg::year_t   new_year,
    output cdc_pkg::day_t    old_day,
    output cdc_pkg::month_t  old_month,
    output cdc_pkg::year_t   old_year
);
    import cdc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic   state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    day_t   day_reg, day_next;
    month_t month_reg, month_next;
    year_t  year_reg, year_next;
    count_t count_reg, count_next;
    day_t   new_day_reg, new_day_next;
    month_t new_month_reg, new_month_next;
    year_t  new_year_reg, new_year_next;
    day_t   old_day_reg, old_day_next;
    month_t old_month_reg, old_month_next;
    year_t  old_year_reg, old_year_next;

    logic   in_fire;
    day_t   cur_len;
    day_t   prev_len;
    month_t prev_month;
    day_t   fwd_day, back_day, load_day;
    month_t fwd_month, back_month, load_month;
    year_t  fwd_year, back_year, load_year;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // shared one-day step unit, forward and back
    always_comb
    begin
        cur_len    = days_in(month_reg, year_reg);
        prev_month = month_reg - MONTH_JAN;
        prev_len   = days_in(prev_month, year_reg);

        if (day_reg < cur_len) begin
            fwd_day   = day_reg + DAY_FIRST;
            fwd_month = month_reg;
            fwd_year  = year_reg;
        end else if (month_reg < MONTH_DEC) begin
            fwd_day   = DAY_FIRST;
            fwd_month = month_reg + MONTH_JAN;
            fwd_year  = year_reg;
        end else begin
            fwd_day   = DAY_FIRST;
            fwd_month = MONTH_JAN;
            fwd_year  = year_reg + YEAR_W'(1);
        end

        if (day_reg > DAY_FIRST) begin
            back_day   = day_reg - DAY_FIRST;
            back_month = month_reg;
            back_year  = year_reg;
        end else if (month_reg <= MONTH_JAN) begin
            back_day   = DAY_MAX;
            back_month = MONTH_DEC;
            back_year  = year_reg - YEAR_W'(1);
        end else begin
            back_day   = prev_len;
            back_month = prev_month;
            back_year  = year_reg;
        end
    end

    // date load with range checks
    always_comb
    begin
        load_month = (set_month >= MONTH_JAN && set_month <= MONTH_DEC) ? set_month : MONTH_JAN;
        load_year  = (set_year >= YEAR_MIN && set_year <= YEAR_MAX) ? set_year : YEAR_MIN;
        load_day   = (set_day >= DAY_FIRST && set_day <= days_in(load_month, load_year))
                     ? set_day : DAY_FIRST;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        count_next     = count_reg;
        new_day_next   = new_day_reg;
        new_month_next = new_month_reg;
        new_year_next  = new_year_reg;
        old_day_next   = old_day_reg;
        old_month_next = old_month_reg;
        old_year_next  = old_year_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    old_day_next   = day_reg;
                    old_month_next = month_reg;
                    old_year_next  = year_reg;
                    unique case (action)
                        ACT_SET:
                        begin
                            day_next   = load_day;
                            month_next = load_month;
                            year_next  = load_year;
                        end
                        ACT_INC:
                        begin
                            day_next   = fwd_day;
                            month_next = fwd_month;
                            year_next  = fwd_year;
                        end
                        ACT_DEC:
                        begin
                            day_next   = back_day;
                            month_next = back_month;
                            year_next  = back_year;
                        end
                        default:
                        begin
                            count_next = add_count;
                        end
                    endcase

                    if (action == ACT_ADD && add_count != '0) begin
                        state_next = ST_RUN;
                    end else begin
                        out_valid_next = 1'b1;
                        new_day_next   = day_next;
                        new_month_next = month_next;
                        new_year_next  = year_next;
                    end
                end
            end
            default:
            begin
                day_next   = fwd_day;
                month_next = fwd_month;
                year_next  = fwd_year;
                count_next = count_reg - COUNT_W'(1);
                // last day of the walk: publish and return to idle
                if (count_reg == COUNT_W'(1)) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    new_day_next   = fwd_day;
                    new_month_next = fwd_month;
                    new_year_next  = fwd_year;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            day_reg       <= DAY_FIRST;
            month_reg     <= MONTH_JAN;
            year_reg      <= YEAR_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg     <= count_next;
        new_day_reg   <= new_day_next;
        new_month_reg <= new_month_next;
        new_year_reg  <= new_year_next;
        old_day_reg   <= old_day_next;
        old_month_reg <= old_month_next;
        old_year_reg  <= old_year_next;
    end

    assign out_valid = out_valid_reg;
    assign new_day   = new_day_reg;
    assign new_month = new_month_reg;
    assign new_year  = new_year_reg;
    assign old_day   = old_day_reg;
    assign old_month = old_month_reg;
    assign old_year  = old_year_reg;

`ifndef NO_ASSERTIONS
    // a running add never has a result pending
    a_run_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !out_valid_reg)
        else $error("result pending during add walk");

    // the walk counter never reaches zero while running
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (count_reg != '0))
        else $error("add walk with zero count");

    // held date is always a legal calendar date
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC)
        && (day_reg >= DAY_FIRST) && (day_reg <= days_in(month_reg, year_reg)))
        else $error("held date out of range");

    // a result appears only with the held date as its new date
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (new_day_reg == day_reg) && (new_month_reg == month_reg)
        && (new_year_reg == year_reg))
        else $error("result does not match held date");
`endif

endmodule
